[sv/bplru_pkg.sv]
// ----------------------------------------------------------------------------
// bplru_pkg
// Shared types, codes and sizing for the buffer pool LRU manager.
// ----------------------------------------------------------------------------
package bplru_pkg;

	localparam int BUFFER_ENTRIES   = 32;
	localparam int DISK_BLOCK_COUNT = 8192;
	localparam int AGE_WIDTH        = 16;

	localparam int IDX_W = (BUFFER_ENTRIES > 1) ? $clog2(BUFFER_ENTRIES) : 1;
	localparam int BLK_W = 13;
	localparam int BND_W = 21;

	// entries per first-level group of the oldest-entry search
	localparam int GRP    = 4;
	localparam int NGRP   = (BUFFER_ENTRIES + GRP - 1) / GRP;

	localparam logic [AGE_WIDTH-1:0] AGE_MAX   = '1;
	localparam logic [BND_W-1:0]     BLK_BOUND = BND_W'(DISK_BLOCK_COUNT);

	typedef enum logic [1:0] {
		REQ_ALLOC  = 2'd0,
		REQ_LOOKUP = 2'd1,
		REQ_DIRTY  = 2'd2,
		REQ_UNDEF  = 2'd3
	} req_code_t;

	typedef enum logic [1:0] {
		STAT_OK   = 2'd0,
		STAT_OOB  = 2'd1,
		STAT_MISS = 2'd2
	} stat_code_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_SCAN,
		S_PICK
	} state_t;

	typedef struct packed {
		logic [1:0]       req_type;
		logic [BLK_W-1:0] block_num;
	} req_t;

	typedef struct packed {
		logic [1:0]       status;
		logic [IDX_W-1:0] buffer_index;
		logic             writeback_valid;
		logic [BLK_W-1:0] writeback_block;
	} rsp_t;

	typedef struct packed {
		logic load;
		logic scan;
		logic commit;
	} cmd_t;

endpackage

[sv/bplru_ctrl.sv]
// ----------------------------------------------------------------------------
// bplru_ctrl
// Request sequencer: accept, scan, pick/commit, then result strobe.
// ----------------------------------------------------------------------------
module bplru_ctrl import bplru_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	output logic busy,
	output logic done,
	output cmd_t cmd
);

	state_t state_q;
	state_t state_d;
	logic   done_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q  <= (state_q == S_PICK);
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (start) state_d = S_SCAN;
			end
			S_SCAN: state_d = S_PICK;
			S_PICK: state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	always_comb begin
		cmd.load   = 1'b0;
		cmd.scan   = 1'b0;
		cmd.commit = 1'b0;
		busy       = 1'b1;
		unique case (state_q)
			S_IDLE: begin
				busy     = 1'b0;
				cmd.load = start;
			end
			S_SCAN: cmd.scan = 1'b1;
			S_PICK: cmd.commit = 1'b1;
			default: busy = 1'b1;
		endcase
	end

	assign done = done_q;

endmodule

[sv/bplru_dp.sv]
// ----------------------------------------------------------------------------
// bplru_dp
// Entry metadata, hit/free/oldest search and update, result register.
// ----------------------------------------------------------------------------
module bplru_dp import bplru_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  cmd_t cmd,
	input  req_t req,
	output rsp_t rsp
);

	logic [BUFFER_ENTRIES-1:0] valid_q;
	logic [BUFFER_ENTRIES-1:0] dirty_q;
	logic [BLK_W-1:0]          tag_q [BUFFER_ENTRIES];
	logic [AGE_WIDTH-1:0]      age_q [BUFFER_ENTRIES];

	req_t req_q;
	rsp_t rsp_q;

	logic [AGE_WIDTH-1:0] aged [BUFFER_ENTRIES];

	logic                 oob_s1;
	logic                 hit_s1;
	logic [IDX_W-1:0]     hit_idx_s1;
	logic                 free_s1;
	logic [IDX_W-1:0]     free_idx_s1;
	logic [AGE_WIDTH-1:0] grp_age_s1 [NGRP];
	logic [IDX_W-1:0]     grp_idx_s1 [NGRP];

	logic                 hit_c;
	logic [IDX_W-1:0]     hit_idx_c;
	logic                 free_c;
	logic [IDX_W-1:0]     free_idx_c;
	logic [AGE_WIDTH-1:0] grp_age_c [NGRP];
	logic [IDX_W-1:0]     grp_idx_c [NGRP];

	logic [IDX_W-1:0]     vic_idx;
	logic [IDX_W-1:0]     sel_idx;
	logic                 is_alloc;
	rsp_t                 rsp_c;

	// saturating age after one allocate
	always_comb begin
		for (int i = 0; i < BUFFER_ENTRIES; i++) begin
			aged[i] = (valid_q[i] && (age_q[i] != AGE_MAX)) ? age_q[i] + 1'b1 : age_q[i];
		end
	end

	// lowest matching and lowest free entries
	always_comb begin
		hit_c      = 1'b0;
		hit_idx_c  = '0;
		free_c     = 1'b0;
		free_idx_c = '0;
		for (int i = BUFFER_ENTRIES - 1; i >= 0; i--) begin
			if (valid_q[i] && (tag_q[i] == req_q.block_num)) begin
				hit_c     = 1'b1;
				hit_idx_c = IDX_W'(i);
			end
			if (!valid_q[i]) begin
				free_c     = 1'b1;
				free_idx_c = IDX_W'(i);
			end
		end
	end

	// first level of the oldest search: one winner per group, lowest index on ties
	always_comb begin
		for (int g = 0; g < NGRP; g++) begin
			grp_age_c[g] = aged[g*GRP];
			grp_idx_c[g] = IDX_W'(g*GRP);
			for (int k = 1; k < GRP; k++) begin
				if ((g*GRP + k < BUFFER_ENTRIES) && (aged[g*GRP+k] > grp_age_c[g])) begin
					grp_age_c[g] = aged[g*GRP+k];
					grp_idx_c[g] = IDX_W'(g*GRP + k);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			req_q <= req;
		end
		if (cmd.scan) begin
			oob_s1      <= ({{(BND_W-BLK_W){1'b0}}, req_q.block_num} >= BLK_BOUND);
			hit_s1      <= hit_c;
			hit_idx_s1  <= hit_idx_c;
			free_s1     <= free_c;
			free_idx_s1 <= free_idx_c;
			for (int g = 0; g < NGRP; g++) begin
				grp_age_s1[g] <= grp_age_c[g];
				grp_idx_s1[g] <= grp_idx_c[g];
			end
		end
		if (cmd.commit) begin
			rsp_q <= rsp_c;
		end
	end

	// second level of the oldest search
	always_comb begin
		logic [AGE_WIDTH-1:0] best_age;
		best_age = grp_age_s1[0];
		vic_idx  = grp_idx_s1[0];
		for (int g = 1; g < NGRP; g++) begin
			if (grp_age_s1[g] > best_age) begin
				best_age = grp_age_s1[g];
				vic_idx  = grp_idx_s1[g];
			end
		end
	end

	assign is_alloc = (req_q.req_type == REQ_ALLOC);
	assign sel_idx  = free_s1 ? free_idx_s1 : vic_idx;

	always_comb begin
		rsp_c = '0;
		priority if (oob_s1) begin
			rsp_c.status = STAT_OOB;
		end else if (is_alloc) begin
			rsp_c.status       = STAT_OK;
			rsp_c.buffer_index = sel_idx;
			if (!free_s1 && dirty_q[vic_idx]) begin
				rsp_c.writeback_valid = 1'b1;
				rsp_c.writeback_block = tag_q[vic_idx];
			end
		end else if (hit_s1) begin
			rsp_c.status       = STAT_OK;
			rsp_c.buffer_index = hit_idx_s1;
		end else begin
			rsp_c.status = STAT_MISS;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			dirty_q <= '0;
			for (int i = 0; i < BUFFER_ENTRIES; i++) begin
				age_q[i] <= '0;
			end
		end else if (cmd.commit && !oob_s1) begin
			if (is_alloc) begin
				for (int i = 0; i < BUFFER_ENTRIES; i++) begin
					age_q[i] <= (sel_idx == IDX_W'(i)) ? '0 : aged[i];
				end
				valid_q[sel_idx] <= 1'b1;
				dirty_q[sel_idx] <= 1'b0;
			end else if (hit_s1 && (req_q.req_type == REQ_DIRTY)) begin
				dirty_q[hit_idx_s1] <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.commit && !oob_s1 && is_alloc) begin
			tag_q[sel_idx] <= req_q.block_num;
		end
	end

	assign rsp = rsp_q;

endmodule

[sv/buffer_pool_lru_manager_unit.sv]
// ----------------------------------------------------------------------------
// buffer_pool_lru_manager_unit
// LRU buffer pool metadata manager: allocate, look up and mark dirty.
// ----------------------------------------------------------------------------
// A request is taken when start is high and busy is low. It then passes through
// the take cycle, a scan cycle (tag match, free search, aged values and
// the per-group oldest search) and a pick cycle (oldest across groups, entry
// update). busy is high during scan and pick; the result appears with done for
// one cycle right after, and a new request may be started in that same cycle,
// so requests do not overlap. The receiver cannot hold results off.
module buffer_pool_lru_manager_unit import bplru_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	output logic busy,
	input  req_t req,
	output logic done,
	output rsp_t rsp
);

	cmd_t cmd;

	bplru_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.done   (done),
		.cmd    (cmd)
	);

	bplru_dp u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd),
		.req    (req),
		.rsp    (rsp)
	);

endmodule

[tb/sv/buffer_pool_lru_manager_unit_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// buffer_pool_lru_manager_unit_tb
// Self-checking bench for the buffer pool LRU manager. A shadow copy of the
// pool metadata predicts every response (allocation, eviction with dirty
// writeback, lookup and mark-dirty hits and misses). Directed requests cover
// field extremes, an empty pool and duplicate allocation, then random
// requests, mostly on buffered blocks, run with several sender idle rates.
// ----------------------------------------------------------------------------
module buffer_pool_lru_manager_unit_tb;
	import bplru_pkg::*;

	localparam int WATCHDOG_LIMIT = 2000;
	localparam int MAX_REPORTS    = 10;
	localparam int DRAIN_CYCLES   = 4;

	logic clk;
	logic arst_n;
	logic start;
	logic busy;
	logic done;
	req_t req;
	rsp_t rsp;

	// shadow pool metadata
	logic                 pool_valid [BUFFER_ENTRIES];
	logic                 pool_dirty [BUFFER_ENTRIES];
	logic [BLK_W-1:0]     pool_tag   [BUFFER_ENTRIES];
	logic [AGE_WIDTH-1:0] pool_age   [BUFFER_ENTRIES];

	rsp_t pending_rsp_q [$];

	int mismatch_cnt;
	int request_cnt;
	int response_cnt;
	int hit_cnt;
	int miss_cnt;
	int evict_cnt;
	int writeback_cnt;
	int quiet_cycles;
	int idle_pct;

	buffer_pool_lru_manager_unit u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.req    (req),
		.done   (done),
		.rsp    (rsp)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	function automatic rsp_t predict_pool(req_t r);
		rsp_t res;
		int   sel;
		res = '0;
		sel = -1;
		if (BND_W'(r.block_num) >= BLK_BOUND) begin
			res.status = STAT_OOB;
		end else if (r.req_type == REQ_ALLOC) begin
			for (int i = 0; i < BUFFER_ENTRIES; i++)
				if (pool_valid[i] && pool_age[i] != AGE_MAX)
					pool_age[i] = pool_age[i] + 1'b1;
			for (int i = 0; i < BUFFER_ENTRIES; i++)
				if (!pool_valid[i] && sel < 0)
					sel = i;
			if (sel < 0) begin
				sel = 0;
				for (int i = 1; i < BUFFER_ENTRIES; i++)
					if (pool_age[i] > pool_age[sel])
						sel = i;
				evict_cnt++;
				if (pool_dirty[sel]) begin
					res.writeback_valid = 1'b1;
					res.writeback_block = pool_tag[sel];
					writeback_cnt++;
				end
			end
			pool_valid[sel] = 1'b1;
			pool_dirty[sel] = 1'b0;
			pool_tag[sel]   = r.block_num;
			pool_age[sel]   = '0;
			res.status       = STAT_OK;
			res.buffer_index = IDX_W'(sel);
		end else begin
			// undefined code behaves as a lookup
			for (int i = 0; i < BUFFER_ENTRIES; i++)
				if (pool_valid[i] && pool_tag[i] == r.block_num && sel < 0)
					sel = i;
			if (sel < 0) begin
				res.status = STAT_MISS;
				miss_cnt++;
			end else begin
				if (r.req_type == REQ_DIRTY)
					pool_dirty[sel] = 1'b1;
				res.status       = STAT_OK;
				res.buffer_index = IDX_W'(sel);
				hit_cnt++;
			end
		end
		return res;
	endfunction

	task automatic report_mismatch(string msg);
		mismatch_cnt++;
		if (mismatch_cnt <= MAX_REPORTS)
			$display("[%0t] mismatch: %s", $realtime, msg);
	endtask

	// response checking, request capture and watchdog
	always @(posedge clk) begin : monitor_blk
		rsp_t want;
		if (arst_n) begin
			if (done) begin
				response_cnt++;
				if (pending_rsp_q.size() == 0) begin
					report_mismatch($sformatf("response with none pending: st=%0d idx=%0d wb=%0b blk=%0d",
						rsp.status, rsp.buffer_index, rsp.writeback_valid, rsp.writeback_block));
				end else begin
					want = pending_rsp_q.pop_front();
					if (rsp.status !== want.status || rsp.buffer_index !== want.buffer_index ||
							rsp.writeback_valid !== want.writeback_valid ||
							rsp.writeback_block !== want.writeback_block)
						report_mismatch($sformatf(
							"resp %0d exp st=%0d idx=%0d wb=%0b blk=%0d got st=%0d idx=%0d wb=%0b blk=%0d",
							response_cnt, want.status, want.buffer_index, want.writeback_valid,
							want.writeback_block, rsp.status, rsp.buffer_index,
							rsp.writeback_valid, rsp.writeback_block));
				end
			end
			if (start && !busy) begin
				pending_rsp_q.push_back(predict_pool(req));
				request_cnt++;
			end
			if (done || (start && !busy))
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("watchdog: no progress for %0d cycles, %0d responses pending",
					quiet_cycles, pending_rsp_q.size());
				$display("CHECK FAILED");
				$finish;
			end
		end
	end

	// called at a falling edge; returns at a falling edge
	task automatic send_req(req_code_t op, logic [BLK_W-1:0] blk);
		req_t r;
		r.req_type  = op;
		r.block_num = blk;
		start <= 1'b1;
		req   <= r;
		do
			@(posedge clk);
		while (busy);
		@(negedge clk);
		if ($urandom_range(0, 99) < idle_pct) begin
			start <= 1'b0;
			@(negedge clk);
			while ($urandom_range(0, 99) < idle_pct)
				@(negedge clk);
		end
	endtask

	task automatic drain_pool();
		start <= 1'b0;
		while (pending_rsp_q.size() != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	function automatic logic [BLK_W-1:0] choose_block_num();
		int live;
		int sel;
		int r;
		live = 0;
		for (int i = 0; i < BUFFER_ENTRIES; i++)
			if (pool_valid[i])
				live++;
		r = $urandom_range(0, 99);
		if (live > 0 && r < 65) begin
			do
				sel = $urandom_range(0, BUFFER_ENTRIES - 1);
			while (!pool_valid[sel]);
			return pool_tag[sel];
		end else if (r < 85) begin
			return BLK_W'($urandom_range(0, 47));
		end
		return BLK_W'($urandom_range(0, DISK_BLOCK_COUNT - 1));
	endfunction

	task automatic test_empty_pool_misses();
		send_req(REQ_LOOKUP, '0);
		send_req(REQ_DIRTY, '1);
		send_req(REQ_UNDEF, 13'h1555);
	endtask

	task automatic test_field_extremes();
		send_req(REQ_ALLOC, '0);
		send_req(REQ_ALLOC, '1);
		send_req(REQ_ALLOC, 13'h1555);
		send_req(REQ_ALLOC, 13'h0AAA);
		send_req(REQ_LOOKUP, 13'h1555);
		send_req(REQ_DIRTY, '0);
		send_req(REQ_UNDEF, 13'h0AAA);
		send_req(REQ_LOOKUP, '1);
	endtask

	task automatic test_duplicate_allocate();
		send_req(REQ_ALLOC, '1);
		send_req(REQ_LOOKUP, '1);
		send_req(REQ_DIRTY, '1);
		send_req(REQ_UNDEF, '1);
		send_req(REQ_LOOKUP, 13'h0001);
		send_req(REQ_DIRTY, 13'h1FFE);
	endtask

	task automatic test_random_mix(int n_items, int pct);
		req_code_t op;
		int        r;
		idle_pct = pct;
		for (int k = 0; k < n_items; k++) begin
			r = $urandom_range(0, 99);
			if (r < 40)
				op = REQ_ALLOC;
			else if (r < 65)
				op = REQ_LOOKUP;
			else if (r < 90)
				op = REQ_DIRTY;
			else
				op = REQ_UNDEF;
			send_req(op, choose_block_num());
			if (k % 100 == 99)
				drain_pool();
		end
		drain_pool();
	endtask

	initial begin
		arst_n       = 1'b0;
		start        = 1'b0;
		req          = '0;
		idle_pct     = 0;
		mismatch_cnt = 0;
		request_cnt  = 0;
		response_cnt = 0;
		hit_cnt      = 0;
		miss_cnt     = 0;
		evict_cnt    = 0;
		writeback_cnt = 0;
		quiet_cycles = 0;
		for (int i = 0; i < BUFFER_ENTRIES; i++) begin
			pool_valid[i] = 1'b0;
			pool_dirty[i] = 1'b0;
			pool_tag[i]   = '0;
			pool_age[i]   = '0;
		end
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		test_empty_pool_misses();
		test_field_extremes();
		test_duplicate_allocate();
		drain_pool();
		test_random_mix(250, 0);
		test_random_mix(200, 78);
		test_random_mix(250, 36);

		$display("Ran %0d requests / %0d responses at sender idle rates 0, 78 and 36 percent",
			request_cnt, response_cnt);
		$display("Saw %0d hits, %0d misses, %0d evictions, %0d dirty writebacks, %0d mismatches",
			hit_cnt, miss_cnt, evict_cnt, writeback_cnt, mismatch_cnt);
		if (mismatch_cnt == 0 && pending_rsp_q.size() == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule

[filelist.f]
sv/bplru_pkg.sv
sv/bplru_ctrl.sv
sv/bplru_dp.sv
sv/buffer_pool_lru_manager_unit.sv
tb/sv/buffer_pool_lru_manager_unit_tb.sv
